// ----- rtl/zlps_pkg.sv -----
// shared types and constants for the z-buffered lit point shader
// no dependencies
`timescale 1ns / 1ps

package zlps_pkg;

  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;
  localparam int IDX_W        = 18;
  localparam int STORE_DEPTH  = 2 ** IDX_W;

  localparam logic [14:0] ONE_Q14     = 15'd16384;
  localparam logic [14:0] AMBIENT_Q14 = 15'd3277;
  localparam logic [7:0]  SPEC_GAIN   = 8'd150;

  localparam logic signed [31:0] DEPTH_FAR = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_MATRIX_X    = 3'd0;
  localparam logic [2:0] CFG_MATRIX_Y    = 3'd1;
  localparam logic [2:0] CFG_MATRIX_Z    = 3'd2;
  localparam logic [2:0] CFG_TRANSLATION = 3'd3;
  localparam logic [2:0] CFG_VIEWER      = 3'd4;
  localparam logic [2:0] CFG_LIGHT       = 3'd5;
  localparam logic [2:0] CFG_HALF        = 3'd6;
  localparam logic [2:0] CFG_BASE_COLOR  = 3'd7;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               use_index;
    logic [IDX_W-1:0]   given_index;
  } in_item_t;

  typedef struct packed {
    logic             written;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } out_item_t;

  typedef struct packed {
    logic [62:0] matrix_row_x;
    logic [62:0] matrix_row_y;
    logic [62:0] matrix_row_z;
    logic [62:0] translation;
    logic [47:0] viewer_dir;
    logic [47:0] light_dir;
    logic [47:0] half_dir;
    logic [23:0] base_color;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_SKIP,
    JOB_DRAW
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] tz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } job_t;

endpackage

// ----- rtl/zbuffer_lit_point_shader_core.sv -----
// top level of the z-buffered lit point shader: configuration registers,
// front end, job queue and back end; depends on zlps_pkg and the zlps_* modules
`timescale 1ns / 1ps

// Requests enter through push/full: a request is taken at a clock edge with push
// high and full low. Results leave through empty/pop: the oldest result sits on
// out_item_o while empty is low and is taken at an edge with pop high.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i, one register
// per cycle; the user must write it only while the block is idle, and the block
// itself does not enforce this. Every request gives exactly one result.
// A draw request runs the transform in the front end (on one multiplier), then
// the back end does the depth read and compare, 12 dot-product steps, 27
// square-root steps, 16 divider steps and 4 steps in the squaring state. The
// back-end sequencer takes a new job only when idle with its output register
// empty, so it finishes one draw before it starts the next. Requests that miss
// the image get their result from the back end's idle state, and those that fail
// the depth test from the compare state. A clear request sweeps the 262144-entry
// depth store, one entry a cycle. After reset the same sweep runs with full held
// high. When the receiver stalls, the result waits in the output register while
// the front end keeps taking requests until the two-entry job queue fills.

module zbuffer_lit_point_shader_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  zlps_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output zlps_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [62:0]         cfg_wdata_i
);
  import zlps_pkg::*;

  cfg_t cfg_q;
  job_t front_job, fifo_job;
  logic front_valid, fifo_ready, fifo_valid, back_ready, back_init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix_row_x <= 63'd1024;
      cfg_q.matrix_row_y <= 63'd1024 << 21;
      cfg_q.matrix_row_z <= 63'd1024 << 42;
      cfg_q.translation  <= '0;
      cfg_q.viewer_dir   <= {1'b0, ONE_Q14, 32'd0};
      cfg_q.light_dir    <= {1'b0, ONE_Q14, 32'd0};
      cfg_q.half_dir     <= {1'b0, ONE_Q14, 32'd0};
      cfg_q.base_color   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATRIX_X:    cfg_q.matrix_row_x <= cfg_wdata_i;
        CFG_MATRIX_Y:    cfg_q.matrix_row_y <= cfg_wdata_i;
        CFG_MATRIX_Z:    cfg_q.matrix_row_z <= cfg_wdata_i;
        CFG_TRANSLATION: cfg_q.translation  <= cfg_wdata_i;
        CFG_VIEWER:      cfg_q.viewer_dir   <= cfg_wdata_i[47:0];
        CFG_LIGHT:       cfg_q.light_dir    <= cfg_wdata_i[47:0];
        CFG_HALF:        cfg_q.half_dir     <= cfg_wdata_i[47:0];
        default:         cfg_q.base_color   <= cfg_wdata_i[23:0];
      endcase
    end
  end

  zlps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .hold_i      (back_init),
    .job_valid_o (front_valid),
    .job_ready_i (fifo_ready),
    .job_o       (front_job)
  );

  zlps_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (fifo_ready),
    .wr_data_i  (front_job),
    .rd_valid_o (fifo_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (fifo_job)
  );

  zlps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (fifo_valid),
    .job_ready_o (back_ready),
    .job_i       (fifo_job),
    .cfg_i       (cfg_q),
    .init_o      (back_init),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/zlps_front.sv -----
// front end: takes requests, runs the affine transform on one shared multiplier
// and works out the pixel index; depends on zlps_pkg
`timescale 1ns / 1ps

module zlps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  zlps_pkg::in_item_t in_item_i,
  input  zlps_pkg::cfg_t    cfg_i,
  input  logic              hold_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output zlps_pkg::job_t    job_o
);
  import zlps_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_FIN, F_IDX, F_PUSH} fstate_e;

  localparam logic signed [56:0] SAT_HI = 57'sd2147483647;
  localparam logic signed [56:0] SAT_LO = -57'sd2147483648;

  fstate_e            state_q;
  in_item_t           item_q;
  logic [1:0]         row_q, term_q;
  logic signed [55:0] acc_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  job_t               job_q;

  logic [62:0]        row_coef;
  logic signed [20:0] coef, off;
  logic signed [31:0] pt;
  logic signed [52:0] prod;
  logic signed [56:0] t_wide;
  logic signed [31:0] t_sat;
  logic [18:0]        rx, ry;
  logic [35:0]        lin;

  function automatic logic [18:0] round_px(logic signed [31:0] t, logic [17:0] lim);
    logic        neg;
    logic [32:0] mag;
    logic [33:0] sum;
    logic [17:0] m;
    neg = t[31];
    mag = neg ? (~{t[31], t} + 33'd1) : {1'b0, t};
    sum = {1'b0, mag} + 34'd32768;
    m   = sum[33:16];
    return {((m == 18'd0) || (!neg && (m < lim))), m};
  endfunction

  always_comb begin
    case (row_q)
      2'd0:    row_coef = cfg_i.matrix_row_x;
      2'd1:    row_coef = cfg_i.matrix_row_y;
      default: row_coef = cfg_i.matrix_row_z;
    endcase
    case (term_q)
      2'd0:    begin coef = row_coef[20:0];  pt = item_q.point_x; end
      2'd1:    begin coef = row_coef[41:21]; pt = item_q.point_y; end
      default: begin coef = row_coef[62:42]; pt = item_q.point_z; end
    endcase
    case (row_q)
      2'd0:    off = cfg_i.translation[20:0];
      2'd1:    off = cfg_i.translation[41:21];
      default: off = cfg_i.translation[62:42];
    endcase
  end

  assign prod   = coef * pt;
  assign t_wide = 57'(acc_q >>> 10) + (57'(off) <<< 6);
  assign t_sat  = (t_wide > SAT_HI) ? 32'sh7fff_ffff :
                  (t_wide < SAT_LO) ? DEPTH_FAR : t_wide[31:0];

  assign rx  = round_px(tx_q, 18'(IMAGE_WIDTH));
  assign ry  = round_px(ty_q, 18'(IMAGE_HEIGHT));
  assign lin = 36'(ry[17:0]) * 36'(IMAGE_WIDTH) + 36'(rx[17:0]);

  assign full        = (state_q != F_IDLE) || hold_i;
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      item_q  <= '0;
      row_q   <= '0;
      term_q  <= '0;
      acc_q   <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
      job_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push && !full) begin
            item_q <= in_item_i;
            row_q  <= '0;
            term_q <= '0;
            acc_q  <= '0;
            job_q  <= '0;
            if (in_item_i.mode) begin
              job_q.kind <= JOB_CLEAR;
              state_q    <= F_PUSH;
            end else begin
              state_q <= F_MAC;
            end
          end
        end
        F_MAC: begin
          acc_q <= acc_q + 56'(prod);
          if (term_q == 2'd2) begin
            state_q <= F_FIN;
          end else begin
            term_q <= term_q + 2'd1;
          end
        end
        F_FIN: begin
          case (row_q)
            2'd0:    tx_q <= t_sat;
            2'd1:    ty_q <= t_sat;
            default: tz_q <= t_sat;
          endcase
          acc_q  <= '0;
          term_q <= '0;
          if (row_q == 2'd2) begin
            state_q <= F_IDX;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= F_MAC;
          end
        end
        F_IDX: begin
          job_q.tz <= tz_q;
          job_q.nx <= item_q.normal_x;
          job_q.ny <= item_q.normal_y;
          job_q.nz <= item_q.normal_z;
          if (item_q.use_index) begin
            job_q.kind <= JOB_DRAW;
            job_q.idx  <= item_q.given_index;
          end else begin
            job_q.kind <= (rx[18] && ry[18]) ? JOB_DRAW : JOB_SKIP;
            job_q.idx  <= lin[IDX_W-1:0];
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/zlps_job_fifo.sv -----
// two-entry queue of jobs between the front and back ends
// depends on zlps_pkg
`timescale 1ns / 1ps

module zlps_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  zlps_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output zlps_pkg::job_t rd_data_o
);
  import zlps_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = slot_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/zlps_back.sv -----
// back end: depth store read-modify-write, clearing sweep and blinn-phong shading
// sequencer with iterative square root and dividers; depends on zlps_pkg
`timescale 1ns / 1ps

module zlps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  zlps_pkg::job_t      job_i,
  input  zlps_pkg::cfg_t      cfg_i,
  output logic                init_o,
  output logic                empty,
  input  logic                pop,
  output zlps_pkg::out_item_t out_item_o
);
  import zlps_pkg::*;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_CLEAR, B_RD, B_CMP, B_DOT, B_PREP, B_SQRT, B_DIVP, B_DIV,
    B_SQ, B_COL
  } bstate_e;

  bstate_e            state_q;
  job_t               job_q;
  logic [IDX_W-1:0]   sweep_q;
  logic signed [31:0] mem_q [STORE_DEPTH];
  logic signed [31:0] rdata_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [1:0]         vec_q, comp_q, sqn_q;
  logic signed [33:0] nn_q, nv_q, nl_q, nh_q;
  logic [55:0]        sq_v_q, sq_r_q, sq_bit_q;
  logic [26:0]        len_q;
  logic [3:0]         div_b_q;
  logic [43:0]        rem_q [2];
  logic [15:0]        quo_q [2];
  logic               zero_q [2];
  logic               sat_q [2];
  logic [14:0]        dif_q, spec_q;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               hit;
  logic signed [15:0] op_a, op_b;
  logic [47:0]        vec_sel;
  logic signed [31:0] dprod;
  logic [55:0]        sq_try;
  logic [43:0]        dsh;
  logic [43:0]        rem_d [2];
  logic               qbit [2];
  logic signed [33:0] dsel [2];
  logic [43:0]        num [2];
  logic [14:0]        cosv [2];
  logic [29:0]        spec_sqr;
  logic [22:0]        spec_term;
  logic [14:0]        light;
  logic [9:0]         chan [3];
  logic [7:0]         chan8 [3];

  assign hit         = (job_q.tz >= rdata_q);
  assign init_o      = (state_q == B_INIT);
  assign job_ready_o = (state_q == B_IDLE) && !out_valid_q;
  assign empty       = !out_valid_q;
  assign out_item_o  = out_q;

  // depth store ports
  assign mem_we    = (state_q == B_INIT) || (state_q == B_CLEAR) || ((state_q == B_CMP) && hit);
  assign mem_waddr = (state_q == B_CMP) ? job_q.idx : sweep_q;
  assign mem_wdata = (state_q == B_CMP) ? job_q.tz : DEPTH_FAR;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[job_q.idx];
  end

  // dot product operands: normal against itself, viewer, light, half
  always_comb begin
    case (vec_q)
      2'd1:    vec_sel = cfg_i.viewer_dir;
      2'd2:    vec_sel = cfg_i.light_dir;
      default: vec_sel = cfg_i.half_dir;
    endcase
    case (comp_q)
      2'd0:    begin op_a = job_q.nx; op_b = signed'(vec_sel[15:0]);  end
      2'd1:    begin op_a = job_q.ny; op_b = signed'(vec_sel[31:16]); end
      default: begin op_a = job_q.nz; op_b = signed'(vec_sel[47:32]); end
    endcase
    if (vec_q == 2'd0) begin
      op_b = op_a;
    end
  end

  assign dprod  = op_a * op_b;
  assign sq_try = sq_r_q + sq_bit_q;

  // two restoring divider lanes share the step counter
  assign dsh     = 44'(len_q) << div_b_q;
  assign dsel[0] = nl_q;
  assign dsel[1] = nh_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qbit[i]  = (rem_q[i] >= dsh);
      rem_d[i] = qbit[i] ? (rem_q[i] - dsh) : rem_q[i];
      num[i]   = {dsel[i][32:0], 11'b0};
      cosv[i]  = zero_q[i] ? 15'd0 :
                 (sat_q[i] || (quo_q[i] > 16'(ONE_Q14))) ? ONE_Q14 : quo_q[i][14:0];
    end
  end

  assign spec_sqr  = 30'(spec_q) * 30'(spec_q);
  assign spec_term = 23'(spec_q) * 23'(SPEC_GAIN);
  assign light     = AMBIENT_Q14 + dif_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c]  = 10'(({1'b0, 23'(light) * 23'(cfg_i.base_color[8*(2-c) +: 8])}
                      + {1'b0, spec_term}) >> 14);
      chan8[c] = (chan[c] > 10'd255) ? 8'd255 : chan[c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      job_q       <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      vec_q       <= '0;
      comp_q      <= '0;
      sqn_q       <= '0;
      nn_q        <= '0;
      nv_q        <= '0;
      nl_q        <= '0;
      nh_q        <= '0;
      sq_v_q      <= '0;
      sq_r_q      <= '0;
      sq_bit_q    <= '0;
      len_q       <= '0;
      div_b_q     <= '0;
      dif_q       <= '0;
      spec_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        rem_q[i]  <= '0;
        quo_q[i]  <= '0;
        zero_q[i] <= 1'b0;
        sat_q[i]  <= 1'b0;
      end
    end else begin
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_INIT, B_CLEAR: begin
          sweep_q <= sweep_q + 1'b1;
          if (&sweep_q) begin
            if (state_q == B_CLEAR) begin
              out_q       <= '0;
              out_valid_q <= 1'b1;
            end
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid_i && !out_valid_q) begin
            job_q   <= job_i;
            sweep_q <= '0;
            case (job_i.kind)
              JOB_CLEAR: state_q <= B_CLEAR;
              JOB_DRAW:  state_q <= B_RD;
              default: begin
                out_q       <= '0;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        B_RD: begin
          state_q <= B_CMP;
        end
        B_CMP: begin
          vec_q  <= '0;
          comp_q <= '0;
          nn_q   <= '0;
          nv_q   <= '0;
          nl_q   <= '0;
          nh_q   <= '0;
          if (hit) begin
            state_q <= B_DOT;
          end else begin
            out_q       <= '0;
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        B_DOT: begin
          case (vec_q)
            2'd0:    nn_q <= nn_q + 34'(dprod);
            2'd1:    nv_q <= nv_q + 34'(dprod);
            2'd2:    nl_q <= nl_q + 34'(dprod);
            default: nh_q <= nh_q + 34'(dprod);
          endcase
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            vec_q  <= vec_q + 2'd1;
            if (vec_q == 2'd3) begin
              state_q <= B_PREP;
            end
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        B_PREP: begin
          // facing away from the viewer flips both lighting terms
          if (nv_q < 0) begin
            nl_q <= -nl_q;
            nh_q <= -nh_q;
          end
          sq_v_q   <= {2'b0, nn_q[31:0], 22'b0};
          sq_r_q   <= '0;
          sq_bit_q <= 56'(1) << 52;
          state_q  <= B_SQRT;
        end
        B_SQRT: begin
          if (sq_v_q >= sq_try) begin
            sq_v_q <= sq_v_q - sq_try;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            state_q <= B_DIVP;
          end
        end
        B_DIVP: begin
          len_q   <= sq_r_q[26:0];
          div_b_q <= 4'd15;
          for (int i = 0; i < 2; i++) begin
            rem_q[i]  <= num[i];
            quo_q[i]  <= '0;
            zero_q[i] <= (dsel[i] <= 0) || (sq_r_q == 56'd0);
            sat_q[i]  <= (num[i] >= {1'b0, sq_r_q[26:0], 16'b0});
          end
          state_q <= B_DIV;
        end
        B_DIV: begin
          for (int i = 0; i < 2; i++) begin
            rem_q[i] <= rem_d[i];
            quo_q[i] <= {quo_q[i][14:0], qbit[i]};
          end
          div_b_q <= div_b_q - 4'd1;
          if (div_b_q == 4'd0) begin
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          if (sqn_q == 2'd0) begin
            dif_q  <= cosv[0];
            spec_q <= cosv[1];
            sqn_q  <= 2'd1;
          end else begin
            spec_q <= spec_sqr[28:14];
            if (sqn_q == 2'd3) begin
              sqn_q   <= '0;
              state_q <= B_COL;
            end else begin
              sqn_q <= sqn_q + 2'd1;
            end
          end
        end
        B_COL: begin
          out_q.written     <= 1'b1;
          out_q.pixel_index <= job_q.idx;
          out_q.red         <= chan8[0];
          out_q.green       <= chan8[1];
          out_q.blue        <= chan8[2];
          out_valid_q       <= 1'b1;
          state_q           <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/zbuffer_lit_point_shader_core_tb.sv -----
// testbench for zbuffer_lit_point_shader_core: directed and random draw/clear
// requests checked against a built-in shading and depth predictor; needs zlps_pkg
`timescale 1ns / 1ps

module zbuffer_lit_point_shader_core_tb;
  import zlps_pkg::*;

  class shade_scoreboard;
    cfg_t        regs;
    int          depth_mem [STORE_DEPTH];
    out_item_t   pending_px [$];
    int unsigned errors;

    function new();
      regs.matrix_row_x = 63'd1024;
      regs.matrix_row_y = 63'd1024 << 21;
      regs.matrix_row_z = 63'd1024 << 42;
      regs.translation  = '0;
      regs.viewer_dir   = 48'(ONE_Q14) << 32;
      regs.light_dir    = 48'(ONE_Q14) << 32;
      regs.half_dir     = 48'(ONE_Q14) << 32;
      regs.base_color   = '0;
      foreach (depth_mem[i]) depth_mem[i] = DEPTH_FAR;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [62:0] val);
      case (idx)
        CFG_MATRIX_X:    regs.matrix_row_x = val;
        CFG_MATRIX_Y:    regs.matrix_row_y = val;
        CFG_MATRIX_Z:    regs.matrix_row_z = val;
        CFG_TRANSLATION: regs.translation  = val;
        CFG_VIEWER:      regs.viewer_dir   = val[47:0];
        CFG_LIGHT:       regs.light_dir    = val[47:0];
        CFG_HALF:        regs.half_dir     = val[47:0];
        CFG_BASE_COLOR:  regs.base_color   = val[23:0];
        default: ;
      endcase
    endfunction

    function longint sx21(logic [20:0] v);
      return longint'($signed(v));
    endfunction

    function longint sx16(logic [15:0] v);
      return longint'($signed(v));
    endfunction

    function longint xform(logic [62:0] row, int k, longint px, longint py, longint pz);
      longint acc, t;
      acc = sx21(row[20:0]) * px + sx21(row[41:21]) * py + sx21(row[62:42]) * pz;
      t = (acc >>> 10) + sx21(regs.translation[21*k +: 21]) * 64;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t;
    endfunction

    function longint round_px(longint t);
      if (t >= 0) return (t + 32768) >>> 16;
      return -((-t + 32768) >>> 16);
    endfunction

    function longint root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function longint dot3(longint nx, longint ny, longint nz, logic [47:0] vec);
      return nx * sx16(vec[15:0]) + ny * sx16(vec[31:16]) + nz * sx16(vec[47:32]);
    endfunction

    function longint cosine(longint d, longint len);
      longint q;
      if (d <= 0 || len == 0) return 0;
      q = (d <<< 11) / len;
      return (q > longint'(ONE_Q14)) ? longint'(ONE_Q14) : q;
    endfunction

    function logic [7:0] chan(longint light, longint spec, logic [7:0] base);
      longint v;
      v = (light * longint'(base) + longint'(SPEC_GAIN) * spec) >>> 14;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function out_item_t shade(in_item_t it);
      out_item_t res;
      longint px, py, pz, nx, ny, nz, tx, ty, tz, x, y, len, nl, nh, dif, sp, light;
      logic [IDX_W-1:0] idx;
      res = '0;
      if (it.mode) begin
        foreach (depth_mem[i]) depth_mem[i] = DEPTH_FAR;
        return res;
      end
      px = longint'(it.point_x); py = longint'(it.point_y); pz = longint'(it.point_z);
      nx = longint'(it.normal_x); ny = longint'(it.normal_y); nz = longint'(it.normal_z);
      tx = xform(regs.matrix_row_x, 0, px, py, pz);
      ty = xform(regs.matrix_row_y, 1, px, py, pz);
      tz = xform(regs.matrix_row_z, 2, px, py, pz);
      if (it.use_index) begin
        idx = it.given_index;
      end else begin
        x = round_px(tx);
        y = round_px(ty);
        if (x < 0 || x >= IMAGE_WIDTH || y < 0 || y >= IMAGE_HEIGHT) return res;
        idx = IDX_W'(y * IMAGE_WIDTH + x);
      end
      if (tz < longint'(depth_mem[idx])) return res;
      depth_mem[idx] = int'(tz);
      len = root(64'(nx * nx + ny * ny + nz * nz) << 22);
      nl = dot3(nx, ny, nz, regs.light_dir);
      nh = dot3(nx, ny, nz, regs.half_dir);
      if (dot3(nx, ny, nz, regs.viewer_dir) < 0) begin
        nl = -nl;
        nh = -nh;
      end
      dif = cosine(nl, len);
      sp = cosine(nh, len);
      repeat (3) sp = (sp * sp) >>> 14;
      light = longint'(AMBIENT_Q14) + dif;
      res.written     = 1'b1;
      res.pixel_index = idx;
      res.red   = chan(light, sp, regs.base_color[23:16]);
      res.green = chan(light, sp, regs.base_color[15:8]);
      res.blue  = chan(light, sp, regs.base_color[7:0]);
      return res;
    endfunction

    function void note_request(in_item_t it);
      pending_px.push_back(shade(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_px.pop_front();
      if (got.written !== want.written) begin
        $display("%0t: written exp %0d got %0d", $time, want.written, got.written);
        errors++;
      end
      if (got.pixel_index !== want.pixel_index) begin
        $display("%0t: pixel_index exp %0d got %0d", $time, want.pixel_index, got.pixel_index);
        errors++;
      end
      if (got.red !== want.red) begin
        $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [62:0] cfg_wdata = '0;
  logic        calm = 1'b0;
  int          pop_hold = 0;

  shade_scoreboard sb = new();

  zbuffer_lit_point_shader_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_request(in_item);
      if (pop && !empty) sb.check_result(out_item);
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #8000000;
    $display("zbuffer_lit_point_shader_core verification failed");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [62:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(in_item_t it);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic in_item_t draw_at(int x, int y, int z, int nx, int ny, int nz);
    in_item_t it;
    it = '0;
    it.point_x = x; it.point_y = y; it.point_z = z;
    it.normal_x = 16'(nx); it.normal_y = 16'(ny); it.normal_z = 16'(nz);
    return it;
  endfunction

  function automatic logic [47:0] rand_dir();
    logic [47:0] v;
    for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(0, 32768) - 16384);
    return v;
  endfunction

  function automatic logic [62:0] near_row(int k);
    logic [62:0] r;
    for (int j = 0; j < 3; j++)
      r[21*j +: 21] = 21'((j == k ? 1024 : 0) + $urandom_range(0, 64) - 32);
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    logic [191:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = 1'b0;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      it.use_index = 1'b0;
      it.point_x = $urandom_range(0, 514 << 16) - (1 << 16);
      it.point_y = $urandom_range(0, 514 << 16) - (1 << 16);
      if (sel < 2) it.point_z = $urandom_range(0, 1 << 20) - (1 << 19);
    end else if (sel < 9) begin
      it.use_index = 1'b1;
      if (sel < 8) it.given_index = IDX_W'($urandom_range(0, 15));
    end
    case ($urandom_range(0, 7))
      0: begin it.normal_x = '0; it.normal_y = '0; it.normal_z = '0; end
      1: begin
        it.normal_x = 16'($urandom_range(0, 4096) - 2048);
        it.normal_y = 16'($urandom_range(0, 4096) - 2048);
        it.normal_z = 16'($urandom_range(0, 4096) - 2048);
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_BASE_COLOR, 63'hFF_FFFF);

    // directed: corners, rounding edges, depth ties and misses, normals
    send_request(draw_at(0, 0, 0, 0, 0, 2048));
    send_request(draw_at(511 << 16, 511 << 16, 100, 0, 0, 2048));
    send_request(draw_at(-32768, 5 << 16, 0, 0, 0, 2048));
    send_request(draw_at(-32767, 5 << 16, 0, 1024, 1024, 1024));
    send_request(draw_at((512 << 16) - 32769, 7 << 16, 0, 0, 0, 2048));
    send_request(draw_at((512 << 16) - 32768, 7 << 16, 0, 0, 0, 2048));
    send_request(draw_at(3 << 16, 3 << 16, 50, 0, 0, -2048));
    send_request(draw_at(3 << 16, 3 << 16, 50, 0, 0, 0));
    send_request(draw_at(3 << 16, 3 << 16, 49, 0, 0, 2048));
    send_request(draw_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32767, 32767, 32767));
    send_request(draw_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         -32768, -32768, -32768));
    send_request(draw_at(9 << 16, 9 << 16, 32'h8000_0000, 32767, -32768, 1));
    it = draw_at(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, -32768, 0, 32767);
    it.use_index = 1'b1; it.given_index = '1;
    send_request(it);
    it.given_index = '0;
    send_request(it);
    it = '0; it.mode = 1'b1;
    send_request(it);
    send_request(draw_at(3 << 16, 3 << 16, 32'h8000_0000, 100, -200, 300));
    send_request(draw_at(3 << 16, 3 << 16, -5, 0, 0, 2048));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_MATRIX_X, near_row(0));
          write_reg(CFG_MATRIX_Y, near_row(1));
          write_reg(CFG_MATRIX_Z, near_row(2));
          write_reg(CFG_TRANSLATION, {21'($urandom_range(0, 2000) - 1000),
                                      21'($urandom_range(0, 2000) - 1000),
                                      21'($urandom_range(0, 2000) - 1000)});
          write_reg(CFG_VIEWER, rand_dir());
          write_reg(CFG_LIGHT, rand_dir());
          write_reg(CFG_HALF, rand_dir());
          write_reg(CFG_BASE_COLOR, 63'($urandom_range(0, 24'hFF_FFFF)));
        end
        2, 3: begin
          for (int r = 0; r < 8; r++)
            write_reg(3'(r), ph == 2 ? '1 : '0);
        end
        4: begin
          for (int r = 0; r < 8; r++) write_reg(3'(r), 63'({$urandom, $urandom}));
        end
        5: begin
          calm <= 1'b1;
          write_reg(CFG_MATRIX_X, 63'd1024);
          write_reg(CFG_MATRIX_Y, 63'd1024 << 21);
          write_reg(CFG_MATRIX_Z, 63'd1024 << 42);
          write_reg(CFG_TRANSLATION, '0);
          write_reg(CFG_VIEWER, rand_dir());
          write_reg(CFG_LIGHT, rand_dir());
          write_reg(CFG_HALF, rand_dir());
          write_reg(CFG_BASE_COLOR, 63'($urandom_range(0, 24'hFF_FFFF)));
        end
        default: write_reg(CFG_BASE_COLOR, 63'($urandom_range(0, 24'hFF_FFFF)));
      endcase
      for (int n = 0; n < 285; n++) begin
        if (ph == 4 && n == 140) begin
          it = random_request();
          it.mode = 1'b1;
        end else begin
          it = random_request();
        end
        send_request(it);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("zbuffer_lit_point_shader_core verification clean");
    end else begin
      $display("zbuffer_lit_point_shader_core verification failed");
    end
    $finish;
  end
endmodule
